>>> sv/tbpt_pkg.sv
// Shared types and constants for the timed blind position tracker.
package tbpt_pkg;

	localparam int POS_W     = 14;
	localparam int RATE_W    = 16;
	localparam int RUN_W     = 24;
	localparam int PROD_W    = 38;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [6:0]       PCT_UNITS = 7'd100;
	localparam logic [RUN_W-1:0] RUN_MAX   = {RUN_W{1'b1}};

	localparam logic [1:0] MOTION_DOWN = 2'd0;
	localparam logic [1:0] MOTION_UP   = 2'd1;
	localparam logic [1:0] MOTION_IDLE = 2'd2;

	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_TARGET = 1'b1;

	localparam logic CFG_MS_UP   = 1'b0;
	localparam logic CFG_MS_DOWN = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [POS_W-1:0] target;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [1:0]       motion;
		logic             drive_up;
		logic             drive_down;
		logic             finished;
	} result_t;

endpackage

>>> sv/timed_blind_position_tracker_core.sv
// Top level of the timed blind position tracker: sequencer, shared multiplier, state.
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_stall     tbpt_pkg::item_t   (mode, target)
//  result    out        result_valid / result_stall tbpt_pkg::result_t (position..finished)
//  cfg       in         cfg_we                      cfg_index, cfg_data
//
// A target command passes twice through the shared 24x16 multiplier, then through the
// bit-serial divider; a tick during a run takes one multiplier pass, then the divider.
// A tick while idle, an ignored command or a tick that ends the run goes from ST_IDLE straight
// to ST_FIN; the next request is taken once the state is back in ST_IDLE.
// item_stall is high from acceptance until the result is loaded into the output register.
// The output register holds a result until taken; a new item may be accepted meanwhile.
// Reset puts both rates at 300 ms per percent and clears all position state.
module timed_blind_position_tracker_core #(
	parameter int POS_SCALE = 10000
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  tbpt_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output tbpt_pkg::result_t           result,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tbpt_pkg::RATE_W-1:0] cfg_data
);
	import tbpt_pkg::*;

	localparam logic [POS_W-1:0] SCALE_POS =
		(POS_SCALE > (2 ** POS_W) - 1) ? {POS_W{1'b1}} : POS_W'(POS_SCALE);
	localparam logic [RUN_W-1:0] SCALE_DIV = RUN_W'(POS_SCALE);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_T,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_APPLY,
		ST_FIN
	} state_t;

	state_t            state_q;

	logic [RATE_W-1:0] ms_up_q;
	logic [RATE_W-1:0] ms_down_q;

	logic [POS_W-1:0]  cur_q;
	logic [POS_W-1:0]  start_q;
	logic [POS_W-1:0]  goal_q;
	logic [RUN_W-1:0]  run_q;
	logic [RUN_W-1:0]  elapsed_q;
	logic              moving_q;
	logic              heading_q;

	logic [POS_W-1:0]  tgt_q;
	logic [POS_W-1:0]  dist_q;
	logic [RATE_W-1:0] rate_q;
	logic              up_q;
	logic              is_cmd_q;
	logic              fin_q;
	logic [PROD_W-1:0] prod_q;

	result_t           res_q;
	logic              res_valid_q;

	logic [POS_W-1:0]  tgt_sat;
	logic              tgt_up;
	logic [RUN_W-1:0]  el_next;
	logic [POS_W-1:0]  span;
	logic [RUN_W-1:0]  mul_a;
	logic [RATE_W-1:0] mul_b;
	logic [RUN_W+RATE_W-1:0] mul_p;
	logic              div_start;
	logic              div_done;
	logic [PROD_W-1:0] div_q;
	logic [RUN_W-1:0]  len_sat;
	logic [POS_W-1:0]  pos_next;
	logic              out_free;

	tbpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (is_cmd_q ? SCALE_DIV : run_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		tgt_sat  = (item.target > SCALE_POS) ? SCALE_POS : item.target;
		tgt_up   = tgt_sat > cur_q;
		el_next  = (elapsed_q != RUN_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		span     = heading_q ? goal_q - start_q : start_q - goal_q;
		len_sat  = (|div_q[PROD_W-1:RUN_W]) ? RUN_MAX : div_q[RUN_W-1:0];
		pos_next = heading_q ? start_q + div_q[POS_W-1:0] : start_q - div_q[POS_W-1:0];
		out_free = !res_valid_q || !result_stall;
		div_start = (state_q == ST_DIV_GO);

		case (state_q)
			ST_MUL_A: begin
				mul_a = RUN_W'(dist_q);
				mul_b = RATE_W'(PCT_UNITS);
			end
			ST_MUL_B: begin
				mul_a = RUN_W'(prod_q[20:0]);
				mul_b = rate_q;
			end
			default: begin
				mul_a = elapsed_q;
				mul_b = RATE_W'(span);
			end
		endcase
		mul_p = {{RATE_W{1'b0}}, mul_a} * {{RUN_W{1'b0}}, mul_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ms_up_q     <= RATE_W'(300);
			ms_down_q   <= RATE_W'(300);
			cur_q       <= '0;
			start_q     <= '0;
			goal_q      <= '0;
			run_q       <= '0;
			elapsed_q   <= '0;
			moving_q    <= 1'b0;
			heading_q   <= 1'b0;
			res_valid_q <= 1'b0;
			fin_q       <= 1'b0;
			is_cmd_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MS_UP:   ms_up_q   <= cfg_data;
					CFG_MS_DOWN: ms_down_q <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == ST_FIN && out_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.mode == MODE_TARGET) begin
							is_cmd_q <= 1'b1;
							fin_q    <= 1'b0;
							if (tgt_sat == goal_q && tgt_sat == cur_q) begin
								state_q <= ST_FIN;
							end else begin
								tgt_q   <= tgt_sat;
								up_q    <= tgt_up;
								dist_q  <= tgt_up ? tgt_sat - cur_q : cur_q - tgt_sat;
								rate_q  <= tgt_up ? ms_up_q : ms_down_q;
								state_q <= ST_MUL_A;
							end
						end else begin
							is_cmd_q <= 1'b0;
							if (!moving_q) begin
								fin_q   <= 1'b0;
								state_q <= ST_FIN;
							end else begin
								elapsed_q <= el_next;
								if (run_q == '0 || el_next > run_q) begin
									// time used up: land on the goal
									cur_q    <= goal_q;
									moving_q <= 1'b0;
									fin_q    <= 1'b1;
									state_q  <= ST_FIN;
								end else begin
									fin_q   <= 1'b0;
									state_q <= ST_MUL_T;
								end
							end
						end
					end
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: state_q <= ST_DIV_GO;
				ST_MUL_T: state_q <= ST_DIV_GO;
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done)
						state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (is_cmd_q) begin
						goal_q    <= tgt_q;
						start_q   <= cur_q;
						run_q     <= len_sat;
						elapsed_q <= '0;
						heading_q <= up_q;
						if (len_sat == '0) begin
							// zero-length run: stop at once on the target
							cur_q    <= tgt_q;
							moving_q <= 1'b0;
							fin_q    <= 1'b1;
						end else begin
							moving_q <= 1'b1;
						end
					end else begin
						cur_q <= pos_next;
						if (pos_next == goal_q) begin
							moving_q <= 1'b0;
							fin_q    <= 1'b1;
						end
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL_A || state_q == ST_MUL_B || state_q == ST_MUL_T)
			prod_q <= mul_p[PROD_W-1:0];
		if (state_q == ST_FIN && out_free) begin
			res_q.position   <= cur_q;
			res_q.motion     <= moving_q ? (heading_q ? MOTION_UP : MOTION_DOWN) : MOTION_IDLE;
			res_q.drive_up   <= moving_q && heading_q;
			res_q.drive_down <= moving_q && !heading_q;
			res_q.finished   <= fin_q;
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

>>> sv/tbpt_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module tbpt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tbpt_pkg::PROD_W-1:0] dividend,
	input  logic [tbpt_pkg::RUN_W-1:0]  divisor,
	output logic                        done,
	output logic [tbpt_pkg::PROD_W-1:0] quotient
);
	import tbpt_pkg::*;

	logic [PROD_W-1:0] dq_q;
	logic [RUN_W-1:0]  rem_q;
	logic [RUN_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [RUN_W:0]    shifted;
	logic [RUN_W:0]    trial;
	logic              fits;

	always_comb begin
		shifted = {rem_q, dq_q[PROD_W-1]};
		fits    = shifted >= {1'b0, dvs_q};
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[PROD_W-2:0], fits};
			rem_q <= fits ? trial[RUN_W-1:0] : shifted[RUN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

>>> tb/sv/tbpt_tracker_checker.sv
// Request/result monitor and position predictor for the timed blind position tracker.
`timescale 1ns / 100ps

module tbpt_tracker_checker
	import tbpt_pkg::*;
#(
	parameter int POS_SCALE = 10000
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  item_t             item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  result_t           result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [RATE_W-1:0] cfg_data,
	output int                fail_count,
	output int                pending,
	output logic [POS_W-1:0]  tracked_pos,
	output logic              tracked_moving
);

	logic [RATE_W-1:0] rate_up   = 16'd300;
	logic [RATE_W-1:0] rate_down = 16'd300;

	logic [POS_W-1:0] pos_now   = '0;
	logic [POS_W-1:0] run_start = '0;
	logic [POS_W-1:0] run_goal  = '0;
	logic [RUN_W-1:0] run_len   = '0;
	logic [RUN_W-1:0] run_time  = '0;
	logic             in_motion = 1'b0;
	logic             going_up  = 1'b0;

	result_t expected_reports[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	assign tracked_pos    = pos_now;
	assign tracked_moving = in_motion;

	// Advance the tracker state by one request and build the report it causes.
	task automatic track_request(input item_t req, output result_t res);
		logic [POS_W-1:0] tgt;
		longint unsigned  diff, rate, len, span, delta, moved;
		logic             stopped;
		stopped = 1'b0;
		if (req.mode == MODE_TARGET) begin
			tgt = req.target;
			if (tgt > POS_SCALE)
				tgt = POS_SCALE[POS_W-1:0];
			// a target equal to both goal and position is dropped
			if (tgt != run_goal || tgt != pos_now) begin
				going_up = tgt > pos_now;
				diff = going_up ? longint'(tgt) - longint'(pos_now)
					: longint'(pos_now) - longint'(tgt);
				rate = going_up ? longint'(rate_up) : longint'(rate_down);
				len = diff * rate * longint'(PCT_UNITS) / longint'(POS_SCALE);
				if (len > longint'(RUN_MAX))
					len = longint'(RUN_MAX);
				run_goal  = tgt;
				run_start = pos_now;
				run_len   = len[RUN_W-1:0];
				run_time  = '0;
				in_motion = 1'b1;
				if (run_len == 0) begin
					pos_now   = run_goal;
					in_motion = 1'b0;
					stopped   = 1'b1;
				end
			end
		end else if (in_motion) begin
			if (run_time < RUN_MAX)
				run_time = run_time + 1'b1;
			if (run_len == 0 || run_time > run_len) begin
				pos_now   = run_goal;
				in_motion = 1'b0;
				stopped   = 1'b1;
			end else begin
				span = going_up ? longint'(run_goal) - longint'(run_start)
					: longint'(run_start) - longint'(run_goal);
				delta = longint'(run_time) * span / longint'(run_len);
				moved = going_up ? longint'(run_start) + delta : longint'(run_start) - delta;
				pos_now = moved[POS_W-1:0];
				if (pos_now == run_goal) begin
					in_motion = 1'b0;
					stopped   = 1'b1;
				end
			end
		end
		res.position   = pos_now;
		res.motion     = in_motion ? (going_up ? MOTION_UP : MOTION_DOWN) : MOTION_IDLE;
		res.drive_up   = in_motion && going_up;
		res.drive_down = in_motion && !going_up;
		res.finished   = stopped;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t want, next;
		if (!arst_n) begin
			rate_up   = 16'd300;
			rate_down = 16'd300;
			pos_now   = '0;
			run_start = '0;
			run_goal  = '0;
			run_len   = '0;
			run_time  = '0;
			in_motion = 1'b0;
			going_up  = 1'b0;
			expected_reports.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MS_UP:   rate_up = cfg_data;
					CFG_MS_DOWN: rate_down = cfg_data;
					default: ;
				endcase
			end
			// compare first: a report never belongs to a request taken at the same edge
			if (result_valid && !result_stall) begin
				if (expected_reports.size() == 0) begin
					$error("result with no request outstanding: position %0d", result.position);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("position", want.position, result.position);
					check_field("motion", want.motion, result.motion);
					check_field("drive_up", want.drive_up, result.drive_up);
					check_field("drive_down", want.drive_down, result.drive_down);
					check_field("finished", want.finished, result.finished);
				end
			end
			if (item_valid && !item_stall) begin
				track_request(item, next);
				expected_reports.push_back(next);
			end
		end
		pending = expected_reports.size();
	end

endmodule

>>> tb/sv/tb_timed_blind_position_tracker_core.sv
// Stimulus and verdict for the timed blind position tracker core.
`timescale 1ns / 100ps

module tb_timed_blind_position_tracker_core;
	import tbpt_pkg::*;

	localparam int POS_SCALE   = 10000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 142;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	item_t             item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	logic              cfg_we = 1'b0;
	logic              cfg_index = CFG_MS_UP;
	logic [RATE_W-1:0] cfg_data = '0;

	int               fail_count;
	int               pending;
	logic [POS_W-1:0] tracked_pos;
	logic             tracked_moving;

	bit quiet = 1'b0;
	int cycle_count = 0;
	int stall_left = 0;
	int free_left = 0;

	always #6 clk = ~clk;

	timed_blind_position_tracker_core #(.POS_SCALE(POS_SCALE)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	tbpt_tracker_checker #(.POS_SCALE(POS_SCALE)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.item           (item),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending),
		.tracked_pos    (tracked_pos),
		.tracked_moving (tracked_moving)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver backpressure: random stall bursts between free stretches, none while quiet.
	always @(negedge clk) begin
		if (quiet) begin
			result_stall = 1'b0;
		end else if (stall_left > 0) begin
			result_stall = 1'b1;
			stall_left--;
		end else if (free_left > 0) begin
			result_stall = 1'b0;
			free_left--;
		end else begin
			result_stall = 1'b0;
			stall_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7);
			free_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
		end
	end

	task automatic send_request(input item_t req);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		item = req;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic send_tick();
		item_t req;
		req.mode = MODE_TICK;
		req.target = POS_W'($urandom_range(0, 16383));
		send_request(req);
	endtask

	task automatic send_target(input int tgt);
		item_t req;
		req.mode = MODE_TARGET;
		req.target = POS_W'(tgt);
		send_request(req);
	endtask

	// Drain all reports and let the core settle before touching the rates.
	task automatic set_rates(input int up_rate, input int down_rate);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_MS_UP;
		cfg_data = RATE_W'(up_rate);
		@(negedge clk);
		cfg_index = CFG_MS_DOWN;
		cfg_data = RATE_W'(down_rate);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic int pick_target(input int here);
		int sel, t;
		sel = $urandom_range(0, 9);
		case (sel)
			0: t = 0;
			1: t = POS_SCALE;
			2: t = $urandom_range(POS_SCALE + 1, 16383);
			3: t = here;
			4, 5: begin
				t = here + $urandom_range(0, 300) - 150;
				if (t < 0)
					t = 0;
				if (t > POS_SCALE)
					t = POS_SCALE;
			end
			default: t = $urandom_range(0, POS_SCALE);
		endcase
		return t;
	endfunction

	initial begin
		int up_rate, down_rate;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset rates: idle tick, ignored target, saturated target, a zero-length run and a short run
		send_tick();
		send_target(0);
		send_target(16383);
		send_tick();
		send_tick();
		send_target(tracked_pos);
		send_target(tracked_pos + 1);
		repeat (4) send_tick();

		// zero rate upward stops at once; a long downward run is overridden
		set_rates(0, 65535);
		send_target(POS_SCALE);
		send_target(0);
		repeat (3) send_tick();
		send_target(9000);

		set_rates(1, 1);
		send_target(POS_SCALE);
		repeat (3) send_tick();
		send_target(9950);
		repeat (2) send_tick();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:  begin up_rate = 1;     down_rate = 1;     end
				1:  begin up_rate = 2;     down_rate = 5;     end
				2:  begin up_rate = 0;     down_rate = 1;     end
				3:  begin up_rate = 1;     down_rate = 0;     end
				4:  begin up_rate = 65535; down_rate = 3;     end
				5:  begin up_rate = 3;     down_rate = 65535; end
				7:  begin up_rate = 0;     down_rate = 0;     end
				8:  begin up_rate = $urandom_range(0, 65535);
					down_rate = $urandom_range(0, 65535); end
				9:  begin up_rate = 4;     down_rate = 4;     end
				default: begin up_rate = $urandom_range(1, 12);
					down_rate = $urandom_range(1, 12); end
			endcase
			set_rates(up_rate, down_rate);
			if (ph == PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// idle: start runs often; moving: mostly ticks, now and then retarget
				if (!tracked_moving ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 24) == 0))
					send_target(pick_target(tracked_pos));
				else
					send_tick();
			end
		end

		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
sv/tbpt_pkg.sv
sv/tbpt_div.sv
sv/timed_blind_position_tracker_core.sv
tb/sv/tbpt_tracker_checker.sv
tb/sv/tb_timed_blind_position_tracker_core.sv
